>>> hdl/prs_pkg.sv
`default_nettype none

package prs_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int ROOT_W  = 33;
	localparam int RAD_W   = 66;
	localparam int REM_W   = 36;
	localparam int RES_W   = 31;
	localparam int CNT_W   = 6;
	localparam int ITER_W  = 6;

	localparam logic [RES_W-1:0]  RES_RESET = 31'd6554;
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIFF_W - 1);

endpackage

`default_nettype wire

>>> hdl/polyline_resampler.sv
// polyline_resampler: turns a stream of waypoints into evenly spaced points.
// Input channel: in_valid/in_ready carry one waypoint (waypoint_x, waypoint_y,
// signed Q16.16, and end_of_path). Output channel: out_valid/out_ready carry
// one point with last_of_run, path_done and count_saturated.
// cfg_wr_en/cfg_wr_data write step_resolution (unsigned Q15.16);
// write it only while the block is idle.
// The first waypoint of a path is stored and gives no point unless it also
// ends the path. Each later waypoint gives count+1 points on the segment from
// the previous waypoint, plus a closing copy if it ends the path.
// Per segment: the magnitudes, the bit-serial sum-of-squares and square-root
// unit, the point count, the bit-serial step dividers, then one point per
// cycle while the receiver keeps up, up to 63 points plus a closing copy.
// in_ready is high only between items; a finished point waits in the output
// register while the next waypoint is taken.
// A stalled receiver holds the point in the output register and the emitter
// waits. Reset clears the stored waypoint, sets step_resolution to 6554 and
// empties the output register.
`default_nettype none

module polyline_resampler #(
	parameter int MAX_STEPS = 62
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [prs_pkg::RES_W-1:0]          cfg_wr_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [prs_pkg::COORD_W-1:0] waypoint_x,
	input  wire logic signed [prs_pkg::COORD_W-1:0] waypoint_y,
	input  wire logic                               end_of_path,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [prs_pkg::COORD_W-1:0]      point_x,
	output logic signed [prs_pkg::COORD_W-1:0]      point_y,
	output logic                                    last_of_run,
	output logic                                    path_done,
	output logic                                    count_saturated
);
	import prs_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);
	localparam logic [2:0]       CNT_LAST = 3'(CNT_W - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ABS   = 7'b0000010,
		ST_SQRT  = 7'b0000100,
		ST_CNT   = 7'b0001000,
		ST_FIN   = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t               state_q;
	logic                 closing_q;
	logic [RES_W-1:0]     res_q;
	logic [COORD_W-1:0]   prev_x_q, prev_y_q;
	logic                 have_prev_q;
	logic [COORD_W-1:0]   cur_x_q, cur_y_q;
	logic                 eop_q;
	logic [DIFF_W-1:0]    dx_q, dy_q;
	logic [DIFF_W-1:0]    ax_q, ay_q;
	logic                 neg_x_q, neg_y_q;
	logic [ROOT_W-1:0]    crem_q;
	logic [RES_W+5:0]     cdiv_q;
	logic [CNT_W-1:0]     cq_q;
	logic [2:0]           cidx_q;
	logic                 big_q;
	logic [CNT_W-1:0]     count_q;
	logic                 sat_q;
	logic [COORD_W-1:0]   stx_q, sty_q;
	logic [COORD_W-1:0]   px_q, py_q;
	logic [CNT_W-1:0]     k_q;

	logic                 out_valid_q;
	logic [COORD_W-1:0]   out_x_q, out_y_q;
	logic                 out_last_q, out_done_q, out_sat_q;

	logic                 accept, out_free, emit_go, close_go;
	logic [DIFF_W-1:0]    abs_x, abs_y;
	logic                 sq_done, div_x_done, div_y_done;
	logic [ROOT_W-1:0]    root;
	logic [DIFF_W-1:0]    qx, qy, nqx, nqy;
	logic                 cge, sat_sel;
	logic [CNT_W-1:0]     cnt_sel;

	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || out_ready;
	assign emit_go  = state_q == ST_EMIT && out_free && !closing_q;
	assign close_go = state_q == ST_EMIT && out_free && closing_q;

	assign abs_x = dx_q[DIFF_W-1] ? ~dx_q + 1'b1 : dx_q;
	assign abs_y = dy_q[DIFF_W-1] ? ~dy_q + 1'b1 : dy_q;

	assign cge     = {{(RES_W+6-ROOT_W){1'b0}}, crem_q} >= cdiv_q;
	assign sat_sel = big_q || cq_q > MAX_CNT;
	assign cnt_sel = sat_sel ? MAX_CNT : (cq_q == '0 ? CNT_W'(1) : cq_q);

	assign nqx = ~qx + 1'b1;
	assign nqy = ~qy + 1'b1;

	prs_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_ABS),
		.mag_a  (abs_x),
		.mag_b  (abs_y),
		.done   (sq_done),
		.root   (root)
	);

	prs_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_FIN),
		.dividend (ax_q),
		.divisor  (cnt_sel),
		.done     (div_x_done),
		.quotient (qx)
	);

	prs_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_FIN),
		.dividend (ay_q),
		.divisor  (cnt_sel),
		.done     (div_y_done),
		.quotient (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (cfg_wr_en) begin
			res_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			closing_q   <= 1'b0;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (have_prev_q) begin
							state_q <= ST_ABS;
						end else if (end_of_path) begin
							state_q   <= ST_EMIT;
							closing_q <= 1'b1;
						end else begin
							prev_x_q    <= waypoint_x;
							prev_y_q    <= waypoint_y;
							have_prev_q <= 1'b1;
						end
					end
				end
				ST_ABS:  state_q <= ST_SQRT;
				ST_SQRT: if (sq_done) state_q <= ST_CNT;
				ST_CNT:  if (cidx_q == CNT_LAST) state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_x_done) begin
						state_q   <= ST_EMIT;
						closing_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (close_go) begin
						state_q     <= ST_IDLE;
						closing_q   <= 1'b0;
						have_prev_q <= 1'b0;
						prev_x_q    <= '0;
						prev_y_q    <= '0;
					end else if (emit_go && k_q == count_q) begin
						if (eop_q) begin
							closing_q <= 1'b1;
						end else begin
							state_q  <= ST_IDLE;
							prev_x_q <= cur_x_q;
							prev_y_q <= cur_y_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= waypoint_x;
			cur_y_q <= waypoint_y;
			eop_q   <= end_of_path;
			dx_q    <= {waypoint_x[COORD_W-1], waypoint_x} - {prev_x_q[COORD_W-1], prev_x_q};
			dy_q    <= {waypoint_y[COORD_W-1], waypoint_y} - {prev_y_q[COORD_W-1], prev_y_q};
		end
		if (state_q == ST_ABS) begin
			ax_q    <= abs_x;
			ay_q    <= abs_y;
			neg_x_q <= dx_q[DIFF_W-1];
			neg_y_q <= dy_q[DIFF_W-1];
		end
		if (state_q == ST_SQRT && sq_done) begin
			crem_q <= root;
			cdiv_q <= {1'b0, res_q, 5'b0};
			big_q  <= {{(RES_W+6-ROOT_W){1'b0}}, root} >= {res_q, 6'b0};
			cq_q   <= '0;
			cidx_q <= '0;
		end
		if (state_q == ST_CNT) begin
			if (cge) begin
				crem_q <= crem_q - cdiv_q[ROOT_W-1:0];
			end
			cq_q   <= {cq_q[CNT_W-2:0], cge};
			cdiv_q <= cdiv_q >> 1;
			cidx_q <= cidx_q + 1'b1;
		end
		if (state_q == ST_FIN) begin
			count_q <= cnt_sel;
			sat_q   <= sat_sel;
		end
		if (state_q == ST_DIV && div_x_done) begin
			stx_q <= neg_x_q ? nqx[COORD_W-1:0] : qx[COORD_W-1:0];
			sty_q <= neg_y_q ? nqy[COORD_W-1:0] : qy[COORD_W-1:0];
			px_q  <= prev_x_q;
			py_q  <= prev_y_q;
			k_q   <= '0;
		end
		if (emit_go) begin
			px_q <= px_q + stx_q;
			py_q <= py_q + sty_q;
			k_q  <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go || close_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_x_q    <= px_q;
			out_y_q    <= py_q;
			out_last_q <= !eop_q && k_q == count_q;
			out_done_q <= 1'b0;
			out_sat_q  <= sat_q;
		end else if (close_go) begin
			out_x_q    <= cur_x_q;
			out_y_q    <= cur_y_q;
			out_last_q <= 1'b1;
			out_done_q <= 1'b1;
			out_sat_q  <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign point_x         = out_x_q;
	assign point_y         = out_y_q;
	assign last_of_run     = out_last_q;
	assign path_done       = out_done_q;
	assign count_saturated = out_sat_q;

	a_close_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && path_done |-> last_of_run && !count_saturated)
		else $error("closing point carries wrong flags");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !closing_q |-> k_q <= count_q)
		else $error("point index ran past segment count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> count_q != '0 && count_q <= MAX_CNT)
		else $error("segment count out of range");

	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && sat_q |-> count_q == MAX_CNT)
		else $error("saturated segment without clipped count");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		div_x_done == div_y_done)
		else $error("step dividers out of step");

endmodule

`default_nettype wire

>>> hdl/prs_isqrt.sv
`default_nettype none

// sum of squares by shift-add, then restoring square root, one bit per cycle
module prs_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [prs_pkg::DIFF_W-1:0] mag_a,
	input  wire logic [prs_pkg::DIFF_W-1:0] mag_b,
	output logic                            done,
	output logic [prs_pkg::ROOT_W-1:0]      root
);
	import prs_pkg::*;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_MUL  = 3'b010,
		SQ_ROOT = 3'b100
	} sq_state_t;

	sq_state_t            state_q;
	logic [ITER_W-1:0]    iter_q;
	logic [DIFF_W-1:0]    ma_q, mb_q, xa_q, xb_q;
	logic [DIFF_W:0]      hi_q;
	logic [DIFF_W-1:0]    lo_q;
	logic [RAD_W-1:0]     rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic                 done_q;

	logic [DIFF_W+1:0]    sum;
	logic [REM_W-1:0]     rs, trial;
	logic                 fits;

	assign sum   = {1'b0, hi_q} + {2'b0, (ma_q[0] ? xa_q : '0)}
	             + {2'b0, (mb_q[0] ? xb_q : '0)};
	assign rs    = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = rs >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						state_q <= SQ_MUL;
						iter_q  <= '0;
					end
				end
				SQ_MUL: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == LAST_ITER) begin
						state_q <= SQ_ROOT;
						iter_q  <= '0;
					end
				end
				SQ_ROOT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == LAST_ITER) begin
						state_q <= SQ_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					ma_q <= mag_a;
					mb_q <= mag_b;
					xa_q <= mag_a;
					xb_q <= mag_b;
					hi_q <= '0;
					lo_q <= '0;
				end
			end
			SQ_MUL: begin
				hi_q <= sum[DIFF_W+1:1];
				lo_q <= {sum[0], lo_q[DIFF_W-1:1]};
				ma_q <= ma_q >> 1;
				mb_q <= mb_q >> 1;
				if (iter_q == LAST_ITER) begin
					rad_q  <= {sum[DIFF_W:1], sum[0], lo_q[DIFF_W-1:1]};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			SQ_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= fits ? rs - trial : rs;
				root_q <= {root_q[ROOT_W-2:0], fits};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> hdl/prs_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module prs_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [prs_pkg::DIFF_W-1:0] dividend,
	input  wire logic [prs_pkg::CNT_W-1:0]  divisor,
	output logic                            done,
	output logic [prs_pkg::DIFF_W-1:0]      quotient
);
	import prs_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [ITER_W-1:0]   iter_q;
	logic [DIFF_W-1:0]   q_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    dvs_q;

	logic [CNT_W:0]      t, diff;
	logic                ge;

	assign t    = {rem_q, q_q[DIFF_W-1]};
	assign ge   = t >= {1'b0, dvs_q};
	assign diff = t - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : t[CNT_W-1:0];
			q_q   <= {q_q[DIFF_W-2:0], ge};
		end else if (start) begin
			rem_q <= '0;
			q_q   <= dividend;
			dvs_q <= divisor;
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

`default_nettype wire

>>> bench/tb_polyline_resampler.sv
`default_nettype none

module tb_polyline_resampler;
	timeunit 1ns;
	timeprecision 1ps;

	import prs_pkg::*;

	localparam int MAX_STEPS   = 62;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 200;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      eop;
	} waypoint_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
		logic                      done;
		logic                      sat;
	} point_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic [RES_W-1:0]          cfg_wr_data = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic signed [COORD_W-1:0] waypoint_x  = '0;
	logic signed [COORD_W-1:0] waypoint_y  = '0;
	logic                      end_of_path = 1'b0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic                      last_of_run;
	logic                      path_done;
	logic                      count_saturated;

	waypoint_t pending_waypoints[$];
	point_t    expected_points[$];

	// predictor state
	logic [RES_W-1:0]          resolution = RES_RESET;
	logic signed [COORD_W-1:0] prev_x     = '0;
	logic signed [COORD_W-1:0] prev_y     = '0;
	logic                      have_prev  = 1'b0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int send_calm      = 0;
	int recv_calm      = 0;
	int items_queued   = 0;
	int items_taken    = 0;
	int points_checked = 0;
	int segments       = 0;
	int clipped_segs   = 0;
	int paths_closed   = 0;
	int errors         = 0;
	int quiet_cycles   = 0;

	polyline_resampler #(
		.MAX_STEPS(MAX_STEPS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.waypoint_x     (waypoint_x),
		.waypoint_y     (waypoint_y),
		.end_of_path    (end_of_path),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.point_x        (point_x),
		.point_y        (point_y),
		.last_of_run    (last_of_run),
		.path_done      (path_done),
		.count_saturated(count_saturated)
	);

	initial forever #1 clk = ~clk;

	task automatic resample_waypoint(input waypoint_t wp);
		longint       dx, dy, ax, ay, step_x, step_y, n_steps;
		logic [127:0] dist_sq, span;
		logic         clipped;
		point_t       pt;
		if (!have_prev) begin
			if (wp.eop) begin
				pt.x    = wp.x;
				pt.y    = wp.y;
				pt.last = 1'b1;
				pt.done = 1'b1;
				pt.sat  = 1'b0;
				expected_points = {expected_points, pt};
				paths_closed++;
			end else begin
				prev_x    = wp.x;
				prev_y    = wp.y;
				have_prev = 1'b1;
			end
			return;
		end
		dx      = longint'(wp.x) - longint'(prev_x);
		dy      = longint'(wp.y) - longint'(prev_y);
		ax      = (dx < 0) ? -dx : dx;
		ay      = (dy < 0) ? -dy : dy;
		dist_sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
		// largest n with (n * spacing)^2 <= length^2, one past the step limit at most
		n_steps = 0;
		for (int c = 1; c <= MAX_STEPS + 1; c++) begin
			span = 128'(c) * 128'(resolution);
			if (n_steps == c - 1 && span * span <= dist_sq)
				n_steps = c;
		end
		clipped = n_steps > MAX_STEPS;
		if (clipped)
			n_steps = MAX_STEPS;
		if (n_steps == 0)
			n_steps = 1;
		step_x = dx / n_steps;
		step_y = dy / n_steps;
		for (longint k = 0; k <= n_steps; k++) begin
			pt.x    = COORD_W'(longint'(prev_x) + step_x * k);
			pt.y    = COORD_W'(longint'(prev_y) + step_y * k);
			pt.last = !wp.eop && k == n_steps;
			pt.done = 1'b0;
			pt.sat  = clipped;
			expected_points = {expected_points, pt};
		end
		segments++;
		if (clipped)
			clipped_segs++;
		if (wp.eop) begin
			pt.x    = wp.x;
			pt.y    = wp.y;
			pt.last = 1'b1;
			pt.done = 1'b1;
			pt.sat  = 1'b0;
			expected_points = {expected_points, pt};
			paths_closed++;
			have_prev = 1'b0;
			prev_x    = '0;
			prev_y    = '0;
		end else begin
			prev_x = wp.x;
			prev_y = wp.y;
		end
	endtask

	task automatic compare_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endtask

	task automatic queue_waypoint(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic eop);
		waypoint_t wp;
		wp.x   = x;
		wp.y   = y;
		wp.eop = eop;
		pending_waypoints = {pending_waypoints, wp};
		items_queued++;
	endtask

	// step around a coordinate by up to about 48 point spacings
	function automatic logic signed [COORD_W-1:0] random_near(
			input logic signed [COORD_W-1:0] from);
		longint reach;
		reach = longint'(resolution) * 48;
		if (reach > 64'sh7FFFFFFF)
			reach = 64'sh7FFFFFFF;
		return COORD_W'(longint'(from) + longint'($urandom_range(0, 32'(2 * reach))) - reach);
	endfunction

	task automatic queue_random_paths(input int n_items);
		logic signed [COORD_W-1:0] cx, cy;
		int                        path_len;
		int                        queued;
		queued = 0;
		cx     = $urandom();
		cy     = $urandom();
		while (queued < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_waypoint($urandom(), $urandom(), 1'($urandom_range(0, 1)));
				queued++;
			end else begin
				path_len = $urandom_range(1, 6);
				for (int i = 0; i < path_len; i++) begin
					if ($urandom_range(0, 5) == 0) begin
						cx = $urandom();
						cy = $urandom();
					end else begin
						cx = random_near(cx);
						cy = random_near(cy);
					end
					queue_waypoint(cx, cy, i == path_len - 1);
					queued++;
				end
			end
		end
	endtask

	task automatic wait_drained(input int settle);
		while (items_taken != items_queued || expected_points.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_phase(input logic [RES_W-1:0] spacing, input int send_pct,
			input int recv_pct, input int n_items);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= spacing;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		resolution     = spacing;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queue_random_paths(n_items / 2);
		// hold off until the first half has fully come out
		wait_drained(0);
		queue_random_paths(n_items - n_items / 2);
		wait_drained(SETTLE);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		waypoint_t nxt;
		logic      take_next;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			waypoint_x  <= '0;
			waypoint_y  <= '0;
			end_of_path <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				nxt.x   = waypoint_x;
				nxt.y   = waypoint_y;
				nxt.eop = end_of_path;
				resample_waypoint(nxt);
				items_taken++;
			end
			if (send_calm > 0)
				send_calm--;
			else if ($urandom_range(0, 31) == 0)
				send_calm = $urandom_range(16, 64);
			if (!in_valid || in_ready) begin
				take_next = pending_waypoints.size() != 0 &&
					(send_calm > 0 || $urandom_range(0, 99) >= send_idle_pct);
				if (take_next) begin
					nxt = pending_waypoints.pop_front();
					waypoint_x  <= nxt.x;
					waypoint_y  <= nxt.y;
					end_of_path <= nxt.eop;
				end
				in_valid <= take_next;
			end
		end
	end

	// point monitor
	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				points_checked++;
				if (expected_points.size() == 0) begin
					$error("unexpected point x=%0d y=%0d", point_x, point_y);
					errors++;
				end else begin
					want = expected_points.pop_front();
					compare_field("point_x", want.x, point_x);
					compare_field("point_y", want.y, point_y);
					compare_field("last_of_run", want.last, last_of_run);
					compare_field("path_done", want.done, path_done);
					compare_field("count_saturated", want.sat, count_saturated);
				end
			end
			if (recv_calm > 0)
				recv_calm--;
			else if ($urandom_range(0, 31) == 0)
				recv_calm = $urandom_range(16, 64);
			out_ready <= recv_calm > 0 || $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
			$display("polyline_resampler: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset spacing of 6554
		queue_waypoint(32'sh7FFFFFFF, 32'sh80000000, 1'b1);
		queue_waypoint(0, 0, 1'b0);
		queue_waypoint(0, 0, 1'b0);
		queue_waypoint(32770, 0, 1'b0);
		queue_waypoint(32770, -39324, 1'b0);
		queue_waypoint(-3, -39324, 1'b0);
		queue_waypoint(39321, 13108, 1'b0);
		queue_waypoint(445669, 13108, 1'b0);
		queue_waypoint(858571, 13108, 1'b0);
		queue_waypoint(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
		queue_waypoint(32'sh80000000, 32'sh80000000, 1'b1);
		queue_waypoint(5, 5, 1'b0);
		queue_waypoint(5, 5, 1'b1);
		queue_waypoint(32'sh55555555, 32'shAAAAAAAA, 1'b0);
		queue_waypoint(32'shAAAAAAAA, 32'sh55555555, 1'b1);
		queue_random_paths(70);
		wait_drained(SETTLE);

		run_phase(RES_W'(1), 88, 0, 85);
		run_phase(RES_W'(32'h7FFFFFFF), 0, 88, 85);
		run_phase(RES_W'($urandom_range(100, 1 << 24)), 37, 37, 85);
		run_phase(RES_W'($urandom_range(1000, 100000)), 0, 0, 85);

		if (expected_points.size() != 0) begin
			$error("%0d expected points never came out", expected_points.size());
			errors++;
		end
		$display("%0d waypoints, %0d segments (%0d clipped to the step limit), %0d paths closed",
			items_taken, segments, clipped_segs, paths_closed);
		$display("%0d points checked over five spacings and four flow-control patterns",
			points_checked);
		if (errors == 0)
			$display("polyline_resampler: match");
		else
			$display("polyline_resampler: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
hdl/prs_pkg.sv
hdl/prs_isqrt.sv
hdl/prs_div.sv
hdl/polyline_resampler.sv
bench/tb_polyline_resampler.sv
